@@ rtl/cce_pkg.sv @@
// Shared types, widths and codes for the circular convolution engine.
package cce_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = SAMPLE_BITS - 1;
  localparam int IDX_W         = 10;
  localparam int TAPCNT_W      = 7;
  localparam int BLKLEN_W      = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 11;
  localparam int MAX_TAPS_DEF  = 64;
  localparam int MAX_BLOCK_DEF = 1024;

  typedef enum logic [1:0] {
    CMD_LOAD_TAP    = 2'd0,
    CMD_LOAD_SAMPLE = 2'd1,
    CMD_COMPUTE     = 2'd2,
    CMD_RSVD        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT    = 2'd0,
    REG_BLOCK_LENGTH = 2'd1,
    REG_RSVD2        = 2'd2,
    REG_RSVD3        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic [IDX_W-1:0]              index;
    logic signed [SAMPLE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]              out_index;
    logic signed [SAMPLE_BITS-1:0] out_value;
    logic                          saturated;
  } out_item_t;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage

@@ rtl/cce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/cce_mac.sv @@
// Shared multiply-accumulate unit: registered product, then wide accumulate.
module cce_mac #(
  parameter int ACC_W = 40
) (
  input  logic                                    clk,
  input  cce_pkg::mac_ctl_t                       ctl,
  input  logic signed [cce_pkg::SAMPLE_BITS-1:0]  tap,
  input  logic signed [cce_pkg::SAMPLE_BITS-1:0]  sample,
  output logic signed [ACC_W-1:0]                 acc
);
  import cce_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;

  logic signed [PROD_W-1:0] product_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      product_r <= tap * sample;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(product_r);
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/circular_convolution_engine.sv @@
// Circular convolution engine top: command decode, tap sequencer, rounding and output.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_item   (cmd, index, value)
//   out_     output     out_valid/out_stall out_item  (out_index, out_value, saturated)
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Loads and ignored commands do not stall the input. A compute holds the input while its taps
// run one tap a cycle through the shared multiply-accumulate; the read and product registers
// then drain (with no taps in use the run is skipped), and the sum is rounded and saturated.
// Reset sets tap_count 1, block_length 1024 and idles the control; the stores keep contents.
// A stalled result holds in the output register; new items are still taken meanwhile,
// but a compute cannot finish until the register is free.
module circular_convolution_engine #(
  parameter int MAX_TAPS  = cce_pkg::MAX_TAPS_DEF,
  parameter int MAX_BLOCK = cce_pkg::MAX_BLOCK_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cce_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cce_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cce_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cce_pkg::*;

  localparam int TAW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SAW   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int ACC_W = 2 * SAMPLE_BITS + TAPCNT_W + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Q_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Q_LO = -Q_HI - ACC_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TAPCNT_W-1:0]    tap_count_r, tap_count_nxt;
  logic [BLKLEN_W-1:0]    block_length_r, block_length_nxt;
  logic [TAPCNT_W-1:0]    taps_r, taps_nxt;
  logic [BLKLEN_W-1:0]    len_r, len_nxt;
  logic [TAPCNT_W-1:0]    m_r, m_nxt;
  logic [BLKLEN_W-1:0]    ptr_r, ptr_nxt;
  logic [IDX_W-1:0]       n_r, n_nxt;
  logic                   v0_r, v0_nxt;
  logic                   v1_r, v1_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic                   in_acc;
  logic [TAPCNT_W-1:0]    taps_eff;
  logic [BLKLEN_W-1:0]    len_eff;
  logic                   issue;
  logic                   tap_wr;
  logic                   samp_wr;
  logic [SAMPLE_BITS-1:0] tap_rd;
  logic [SAMPLE_BITS-1:0] samp_rd;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] acc_q;
  mac_ctl_t               mac_ctl;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign taps_eff = (32'(tap_count_r) > MAX_TAPS) ? TAPCNT_W'(MAX_TAPS) : tap_count_r;
  assign len_eff  = (32'(block_length_r) > MAX_BLOCK) ? BLKLEN_W'(MAX_BLOCK) : block_length_r;

  assign tap_wr  = in_acc && (in_item.cmd == CMD_LOAD_TAP) && (32'(in_item.index) < MAX_TAPS);
  assign samp_wr = in_acc && (in_item.cmd == CMD_LOAD_SAMPLE)
                   && (32'(in_item.index) < MAX_BLOCK);
  assign issue   = (state_r == ST_RUN);

  cce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS), .AW(TAW)) u_tap_ram (
    .clk     (clk),
    .wr_en   (tap_wr),
    .wr_addr (TAW'(in_item.index)),
    .wr_data (in_item.value),
    .rd_addr (TAW'(m_r)),
    .rd_data (tap_rd)
  );

  cce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_BLOCK), .AW(SAW)) u_sample_ram (
    .clk     (clk),
    .wr_en   (samp_wr),
    .wr_addr (SAW'(in_item.index)),
    .wr_data (in_item.value),
    .rd_addr (SAW'(ptr_r)),
    .rd_data (samp_rd)
  );

  assign mac_ctl.clr    = in_acc && (in_item.cmd == CMD_COMPUTE);
  assign mac_ctl.mul_en = v0_r;
  assign mac_ctl.acc_en = v1_r;

  cce_mac #(.ACC_W(ACC_W)) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .tap    (signed'(tap_rd)),
    .sample (signed'(samp_rd)),
    .acc    (acc)
  );

  // Round half up: add one half LSB, then floor by arithmetic shift.
  assign acc_rnd = acc + HALF;
  assign acc_q   = acc_rnd >>> FRAC_BITS;

  always_comb begin
    state_nxt        = state_r;
    tap_count_nxt    = tap_count_r;
    block_length_nxt = block_length_r;
    taps_nxt         = taps_r;
    len_nxt          = len_r;
    m_nxt            = m_r;
    ptr_nxt          = ptr_r;
    n_nxt            = n_r;
    v0_nxt           = issue;
    v1_nxt           = v0_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_item_nxt     = out_item_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TAP_COUNT:    tap_count_nxt = cfg_data[TAPCNT_W-1:0];
        REG_BLOCK_LENGTH: block_length_nxt = cfg_data[BLKLEN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_item.cmd == CMD_COMPUTE) && (len_eff != '0)
            && ({1'b0, in_item.index} < len_eff)) begin
          taps_nxt  = taps_eff;
          len_nxt   = len_eff;
          m_nxt     = '0;
          ptr_nxt   = {1'b0, in_item.index};
          n_nxt     = in_item.index;
          state_nxt = (taps_eff == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        m_nxt   = m_r + TAPCNT_W'(1);
        ptr_nxt = (ptr_r == '0) ? (len_r - BLKLEN_W'(1)) : (ptr_r - BLKLEN_W'(1));
        if (m_r == taps_r - TAPCNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v0_r && !v1_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.out_index = n_r;
          if (acc_q > Q_HI) begin
            out_item_nxt.out_value = Q_HI[SAMPLE_BITS-1:0];
            out_item_nxt.saturated = 1'b1;
          end else if (acc_q < Q_LO) begin
            out_item_nxt.out_value = Q_LO[SAMPLE_BITS-1:0];
            out_item_nxt.saturated = 1'b1;
          end else begin
            out_item_nxt.out_value = acc_q[SAMPLE_BITS-1:0];
            out_item_nxt.saturated = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      tap_count_r    <= TAPCNT_W'(1);
      block_length_r <= BLKLEN_W'(1024);
      v0_r           <= 1'b0;
      v1_r           <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      tap_count_r    <= tap_count_nxt;
      block_length_r <= block_length_nxt;
      v0_r           <= v0_nxt;
      v1_r           <= v1_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    taps_r     <= taps_nxt;
    len_r      <= len_nxt;
    m_r        <= m_nxt;
    ptr_r      <= ptr_nxt;
    n_r        <= n_nxt;
    out_item_r <= out_item_nxt;
  end

  // A new result only appears out of the rounding step.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside rounding step");

  // Rounding must see the final sum: product pipeline empty.
  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (!v0_r && !v1_r))
    else $error("rounding with products still in flight");

  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (m_r < taps_r))
    else $error("tap counter past tap count");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (ptr_r < len_r))
    else $error("sample pointer outside block");

  // Pipeline only fills from issued taps.
  a_pipe_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v0_r) |-> $past(state_r == ST_RUN))
    else $error("product stage loaded without a tap issue");

endmodule
